@@ sv/cleb_pkg.sv @@
// Shared definitions for the console line edit buffer.
// Holds key codes, the default ring depth and the result word type; no dependencies.
package cleb_pkg;

    localparam int BUF_DEPTH_DEF = 128;

    localparam logic [7:0] KEY_DUMP = 8'h10;   // Ctrl-P
    localparam logic [7:0] KEY_KILL = 8'h15;   // Ctrl-U
    localparam logic [7:0] KEY_BS   = 8'h08;   // Ctrl-H
    localparam logic [7:0] KEY_DEL  = 8'h7F;
    localparam logic [7:0] KEY_EOF  = 8'h04;   // Ctrl-D
    localparam logic [7:0] KEY_CR   = 8'h0D;
    localparam logic [7:0] KEY_LF   = 8'h0A;
    localparam logic [7:0] KEY_NUL  = 8'h00;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       line_committed;
        logic       dump_request;
        logic       read_valid;
        logic [7:0] read_char;
        logic       read_eof;
        logic       read_empty;
        logic       read_line_end;
    } t_result;

endpackage

@@ sv/cleb_ram.sv @@
// Generic single-write, single-read RAM with a registered, read-first read port.
// No dependencies.
module cleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/cleb_step.sv @@
// Combinational work for one word: key decode, pointer arithmetic and read pop.
// Depends on cleb_pkg.
module cleb_step #(
    parameter int BUF_DEPTH = cleb_pkg::BUF_DEPTH_DEF
) (
    input  logic                           i_kind,
    input  logic [7:0]                     i_key_code,
    input  logic                           i_read_started,
    input  logic [$clog2(2*BUF_DEPTH)-1:0] i_rd_ptr,
    input  logic [$clog2(2*BUF_DEPTH)-1:0] i_cm_ptr,
    input  logic [$clog2(2*BUF_DEPTH)-1:0] i_ed_ptr,
    input  logic [7:0]                     i_rd_data,
    output cleb_pkg::t_result              o_result,
    output logic [$clog2(2*BUF_DEPTH)-1:0] o_n_rd_ptr,
    output logic [$clog2(BUF_DEPTH)-1:0]   o_n_rd_slot,
    output logic [$clog2(2*BUF_DEPTH)-1:0] o_n_cm_ptr,
    output logic [$clog2(2*BUF_DEPTH)-1:0] o_n_ed_ptr,
    output logic                           o_we,
    output logic [$clog2(BUF_DEPTH)-1:0]   o_waddr,
    output logic [7:0]                     o_wdata
);
    import cleb_pkg::*;

    localparam int PTR_W  = $clog2(2*BUF_DEPTH);
    localparam int ADDR_W = $clog2(BUF_DEPTH);
    localparam logic [PTR_W:0]   PTR_MOD  = (PTR_W+1)'(2*BUF_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2*BUF_DEPTH - 1);
    localparam logic [PTR_W-1:0] DEPTH_P  = PTR_W'(BUF_DEPTH);
    localparam logic [PTR_W-1:0] DEPTH_M1 = PTR_W'(BUF_DEPTH - 1);

    // Pointers run modulo twice the depth so that full and empty differ.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_diff(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + PTR_MOD - {1'b0, b});
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] s;
        s = (p >= DEPTH_P) ? p - DEPTH_P : p;
        return s[ADDR_W-1:0];
    endfunction

    logic [PTR_W-1:0] d_edit_read;
    logic [PTR_W-1:0] d_edit_commit;
    logic [7:0]       key_mapped;

    assign d_edit_read   = ptr_diff(i_ed_ptr, i_rd_ptr);
    assign d_edit_commit = ptr_diff(i_ed_ptr, i_cm_ptr);
    assign key_mapped    = (i_key_code == KEY_CR) ? KEY_LF : i_key_code;

    always_comb begin
        o_result   = '0;
        o_n_rd_ptr = i_rd_ptr;
        o_n_cm_ptr = i_cm_ptr;
        o_n_ed_ptr = i_ed_ptr;
        o_we       = 1'b0;
        o_waddr    = ptr_slot(i_ed_ptr);
        o_wdata    = key_mapped;
        if (i_kind == KIND_KEY) begin
            priority if (i_key_code == KEY_DUMP) begin
                o_result.dump_request = 1'b1;
            end else if (i_key_code == KEY_KILL) begin
                o_result.erase_count = (32'(d_edit_commit) > 32'd255)
                                       ? 8'hFF : 8'(32'(d_edit_commit));
                o_n_ed_ptr = i_cm_ptr;
            end else if (i_key_code == KEY_BS || i_key_code == KEY_DEL) begin
                if (i_ed_ptr != i_cm_ptr) begin
                    o_n_ed_ptr = ptr_dec(i_ed_ptr);
                    o_result.erase_count = 8'd1;
                end
            end else if (i_key_code != KEY_NUL && d_edit_read < DEPTH_P) begin
                o_we                = 1'b1;
                o_n_ed_ptr          = ptr_inc(i_ed_ptr);
                o_result.echo_valid = 1'b1;
                o_result.echo_char  = key_mapped;
                // The store that takes the last free slot commits as well.
                if (key_mapped == KEY_LF || key_mapped == KEY_EOF ||
                    d_edit_read == DEPTH_M1) begin
                    o_n_cm_ptr              = ptr_inc(i_ed_ptr);
                    o_result.line_committed = 1'b1;
                end
            end else begin
                // Dropped key: nothing changes.
            end
        end else begin
            if (i_rd_ptr == i_cm_ptr) begin
                o_result.read_empty = 1'b1;
            end else if (i_rd_data == KEY_EOF) begin
                o_result.read_eof = 1'b1;
                if (!i_read_started) begin
                    o_n_rd_ptr = ptr_inc(i_rd_ptr);
                end
            end else begin
                o_n_rd_ptr             = ptr_inc(i_rd_ptr);
                o_result.read_valid    = 1'b1;
                o_result.read_char     = i_rd_data;
                o_result.read_line_end = (i_rd_data == KEY_LF);
            end
        end
        o_n_rd_slot = ptr_slot(o_n_rd_ptr);
    end

endmodule

@@ sv/console_line_edit_buffer.sv @@
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-----------------------------------------
// input    | in        | i_in_valid/o_in_stall | i_kind, i_key_code, i_read_started
// result   | out       | o_out_valid/i_out_stall | o_echo_*, o_erase_count, o_read_*, ...
//
// One word is accepted per cycle while o_in_stall is low; its result word is registered after acceptance
// (input register, then the pointer logic into the result register).
// The ring's read data is prefetched every cycle at the next read slot, with a bypass for a
// same-cycle write, so the read pop never waits on the memory port.
// Synchronous active-low reset empties the ring by zeroing the three pointers; no clearing pass.
// A stalled result holds the pipeline: the input register still takes one more word.
// Top level of the console line edit buffer. Depends on cleb_pkg, cleb_ram and cleb_step.
module console_line_edit_buffer #(
    parameter int BUF_DEPTH = cleb_pkg::BUF_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_key_code,
    input  logic       i_read_started,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_char,
    output logic [7:0] o_erase_count,
    output logic       o_line_committed,
    output logic       o_dump_request,
    output logic       o_read_valid,
    output logic [7:0] o_read_char,
    output logic       o_read_eof,
    output logic       o_read_empty,
    output logic       o_read_line_end
);
    import cleb_pkg::*;

    localparam int PTR_W  = $clog2(2*BUF_DEPTH);
    localparam int ADDR_W = $clog2(BUF_DEPTH);

    logic              r_in_valid;
    logic              r_kind;
    logic [7:0]        r_key_code;
    logic              r_read_started;
    logic              r_out_valid;
    t_result           r_result;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_cm_ptr;
    logic [PTR_W-1:0]  r_ed_ptr;
    logic [ADDR_W-1:0] r_rd_slot;
    logic              r_byp_hit;
    logic [7:0]        r_byp_data;

    logic              fire;
    logic              in_accept;
    t_result           step_result;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [PTR_W-1:0]  n_cm_ptr;
    logic [PTR_W-1:0]  n_ed_ptr;
    logic [ADDR_W-1:0] n_rd_slot;
    logic [ADDR_W-1:0] step_rd_slot;
    logic              step_we;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic [7:0]        rd_data;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign ram_we     = fire && step_we;
    assign n_rd_slot  = fire ? step_rd_slot : r_rd_slot;
    // The memory returns old data when its read and write slots coincide.
    assign rd_data    = r_byp_hit ? r_byp_data : ram_rdata;

    cleb_step #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_step (
        .i_kind        (r_kind),
        .i_key_code    (r_key_code),
        .i_read_started(r_read_started),
        .i_rd_ptr      (r_rd_ptr),
        .i_cm_ptr      (r_cm_ptr),
        .i_ed_ptr      (r_ed_ptr),
        .i_rd_data     (rd_data),
        .o_result      (step_result),
        .o_n_rd_ptr    (n_rd_ptr),
        .o_n_rd_slot   (step_rd_slot),
        .o_n_cm_ptr    (n_cm_ptr),
        .o_n_ed_ptr    (n_ed_ptr),
        .o_we          (step_we),
        .o_waddr       (ram_waddr),
        .o_wdata       (ram_wdata)
    );

    cleb_ram #(
        .WIDTH(8),
        .DEPTH(BUF_DEPTH)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(n_rd_slot),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ptr    <= '0;
            r_cm_ptr    <= '0;
            r_ed_ptr    <= '0;
            r_rd_slot   <= '0;
            r_byp_hit   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_rd_ptr    <= n_rd_ptr;
                r_cm_ptr    <= n_cm_ptr;
                r_ed_ptr    <= n_ed_ptr;
                r_rd_slot   <= step_rd_slot;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_byp_hit <= ram_we && (ram_waddr == n_rd_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind         <= i_kind;
            r_key_code     <= i_key_code;
            r_read_started <= i_read_started;
        end
        if (fire) begin
            r_result <= step_result;
        end
        r_byp_data <= ram_wdata;
    end

    assign o_out_valid      = r_out_valid;
    assign o_echo_valid     = r_result.echo_valid;
    assign o_echo_char      = r_result.echo_char;
    assign o_erase_count    = r_result.erase_count;
    assign o_line_committed = r_result.line_committed;
    assign o_dump_request   = r_result.dump_request;
    assign o_read_valid     = r_result.read_valid;
    assign o_read_char      = r_result.read_char;
    assign o_read_eof       = r_result.read_eof;
    assign o_read_empty     = r_result.read_empty;
    assign o_read_line_end  = r_result.read_line_end;

endmodule

@@ sv/cleb_checker.sv @@
// Port-level checks for the console line edit buffer, bound to the top level.
// Depends on cleb_pkg and console_line_edit_buffer.
module cleb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_kind,
    input logic [7:0] i_key_code,
    input logic       i_read_started,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_echo_valid,
    input logic [7:0] o_echo_char,
    input logic [7:0] o_erase_count,
    input logic       o_line_committed,
    input logic       o_dump_request,
    input logic       o_read_valid,
    input logic [7:0] o_read_char,
    input logic       o_read_eof,
    input logic       o_read_empty,
    input logic       o_read_line_end
);
    import cleb_pkg::*;

    // A word does at most one thing: echo, dump, deliver, end of file or empty.
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_echo_valid, o_dump_request, o_read_valid,
                                  o_read_eof, o_read_empty}))
        else $error("more than one action in a result word");

    // Only a stored key can commit a line, and it is never erased by the same word.
    a_commit_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_committed) |-> (o_echo_valid && o_erase_count == 8'd0))
        else $error("line commit without a stored key");

    // The line end flag goes with a delivered newline only.
    a_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_line_end) |-> (o_read_valid && o_read_char == KEY_LF))
        else $error("line end flag without a delivered newline");

    // A delivered byte is never Ctrl-D, and a stored key is never a carriage return.
    a_mapping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_read_valid && o_read_char == KEY_EOF) &&
                         !(o_echo_valid && o_echo_char == KEY_CR)))
        else $error("character mapping broken");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_echo_char) &&
                                          $stable(o_read_char) && $stable(o_erase_count)))
        else $error("stalled result word changed");

endmodule

bind console_line_edit_buffer cleb_checker u_cleb_checker (.*);
